/* hw/rtl/ffsa_pkg.sv */
// Package with the types, constants and a helper function of the segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W       = 20;
    localparam int CAP_W        = 21;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [CAP_W-1:0]     CAP_MAX          = {CAP_W{1'b1}};
    localparam logic [CAP_W-1:0]     POOL_SIZE_RESET  = CAP_W'(65536);
    localparam logic [BYTE_W-1:0]    HEADER_RESET     = BYTE_W'(52);
    localparam logic [BYTE_W-1:0]    OVERHEAD_RESET   = BYTE_W'(56);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD     = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_UNKNOWN   = 2'd3
    } t_status;

    typedef struct packed {
        logic              used;
        logic [CAP_W-1:0]  cap;
        logic [ADDR_W-1:0] off;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

    typedef enum logic [2:0] {
        RD_I, RD_I_P1, RD_I_M1, RD_K_M1, RD_K_P1
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_INIT, WR_SHIFT, WR_SPLIT_NEW, WR_GRANT_REQ, WR_GRANT_FULL, WR_FREE, WR_PREV_MERGE
    } t_wr_sel;

    typedef enum logic [2:0] {
        K_HOLD, K_CNT, K_I_P1, K_I, K_DEC, K_INC
    } t_k_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CHK, S_AL_DEC, S_SU_RD, S_SU_WR, S_AL_WR,
        S_FR_NRD, S_FR_NCHK, S_NM_RD, S_NM_WR, S_FR_PRD, S_FR_PCHK, S_PM_RD, S_PM_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    item_load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    i_clr;
        logic    i_inc;
        logic    cur_load;
        logic    merge_next;
        t_k_op   k_op;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    do_init;
        logic    st_we;
        t_status st_val;
        logic    grant_we;
        logic    publish;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  ready;
        logic  scan_end;
        logic  alloc_hit;
        logic  free_hit;
        logic  split;
        logic  nxt_exists;
        logic  prv_exists;
        logic  rd_free;
        logic  su_more;
        logic  sd_more;
        logic  out_free;
    } t_stat;

    function automatic logic [CAP_W-1:0] cap_sum(input logic [CAP_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [CAP_W-1:0] c);
        logic [CAP_W+1:0] s;
        s = (CAP_W+2)'(a) + (CAP_W+2)'(b) + (CAP_W+2)'(c);
        return (s > (CAP_W+2)'(CAP_MAX)) ? CAP_MAX : s[CAP_W-1:0];
    endfunction

endpackage

/* hw/rtl/ffsa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/ffsa_dp.sv */
// Datapath of the segment allocator: configuration, segment table, indices and result.
`timescale 1ns / 1ps
module ffsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ffsa_pkg::CAP_W-1:0]     i_cfg_data,
    input  logic [1:0]                    i_mode,
    input  logic [ffsa_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic                          i_out_ready,
    input  ffsa_pkg::t_cmd                i_cmd,
    output ffsa_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output logic [ffsa_pkg::OUT_TDATA_W-1:0] o_out_tdata,
    output logic [1:0]                    o_out_status
);
    import ffsa_pkg::*;

    logic [CAP_W-1:0]  r_pool;
    logic [BYTE_W-1:0] r_hdr;
    logic [BYTE_W-1:0] r_ovh;
    t_mode             r_mode;
    logic [CAP_W-1:0]  r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ready;
    t_seg              r_cur;
    t_status           r_st;
    logic [ADDR_W-1:0] r_grant;
    logic              r_ovalid;
    t_status           r_ostatus;
    logic [ADDR_W-1:0] r_ograddr;

    logic [SEG_W-1:0]  w_rdata;
    t_seg              w_rd;
    logic [IDX_W-1:0]  w_raddr;
    logic [IDX_W-1:0]  w_waddr;
    t_seg              w_wseg;
    logic [CNT_W-1:0]  w_i_p1;
    logic [CNT_W-1:0]  w_k_p1;
    logic [CAP_W:0]    w_req_ovh;

    assign w_rd      = t_seg'(w_rdata);
    assign w_i_p1    = r_i + CNT_W'(1);
    assign w_k_p1    = r_k + CNT_W'(1);
    assign w_req_ovh = (CAP_W+1)'(r_req) + (CAP_W+1)'(r_ovh);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_I:    w_raddr = r_i[IDX_W-1:0];
            RD_I_P1: w_raddr = w_i_p1[IDX_W-1:0];
            RD_I_M1: w_raddr = IDX_W'(r_i - CNT_W'(1));
            RD_K_M1: w_raddr = IDX_W'(r_k - CNT_W'(1));
            RD_K_P1: w_raddr = w_k_p1[IDX_W-1:0];
            default: w_raddr = r_i[IDX_W-1:0];
        endcase
    end

    always_comb begin
        w_waddr = r_i[IDX_W-1:0];
        w_wseg  = r_cur;
        case (i_cmd.wr_sel)
            WR_INIT: begin
                w_waddr      = '0;
                w_wseg.used  = 1'b0;
                w_wseg.off   = '0;
                w_wseg.cap   = (r_pool >= CAP_W'(r_ovh)) ? r_pool - CAP_W'(r_ovh) : '0;
            end
            WR_SHIFT: begin
                w_waddr = r_k[IDX_W-1:0];
                w_wseg  = w_rd;
            end
            WR_SPLIT_NEW: begin
                w_waddr     = w_i_p1[IDX_W-1:0];
                w_wseg.used = 1'b0;
                w_wseg.cap  = r_cur.cap - w_req_ovh[CAP_W-1:0];
                w_wseg.off  = r_cur.off + w_req_ovh[ADDR_W-1:0];
            end
            WR_GRANT_REQ: begin
                w_wseg.used = 1'b1;
                w_wseg.cap  = r_req;
            end
            WR_GRANT_FULL: begin
                w_wseg.used = 1'b1;
            end
            WR_FREE: begin
                w_wseg.used = 1'b0;
            end
            WR_PREV_MERGE: begin
                w_waddr     = IDX_W'(r_i - CNT_W'(1));
                w_wseg.used = 1'b0;
                w_wseg.cap  = cap_sum(w_rd.cap, r_ovh, r_cur.cap);
                w_wseg.off  = w_rd.off;
            end
            default: begin
                w_wseg = r_cur;
            end
        endcase
    end

    ffsa_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(w_waddr),
        .i_wdata(w_wseg),
        .i_re   (i_cmd.rd_en),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool   <= POOL_SIZE_RESET;
            r_hdr    <= HEADER_RESET;
            r_ovh    <= OVERHEAD_RESET;
            r_cnt    <= '0;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_SIZE: r_pool <= i_cfg_data;
                    CFG_HEADER:    r_hdr  <= i_cfg_data[BYTE_W-1:0];
                    CFG_OVERHEAD:  r_ovh  <= i_cfg_data[BYTE_W-1:0];
                    default:       r_pool <= r_pool;
                endcase
            end
            if (i_cmd.do_init) begin
                r_cnt   <= CNT_W'(1);
                r_ready <= 1'b1;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.publish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_mode  <= t_mode'(i_mode);
            r_req   <= i_tdata[CAP_W-1:0];
            r_addr  <= i_tdata[CAP_W +: ADDR_W];
            r_st    <= ST_OK;
            r_grant <= '0;
        end
        if (i_cmd.st_we) begin
            r_st <= i_cmd.st_val;
        end
        if (i_cmd.grant_we) begin
            r_grant <= r_cur.off + ADDR_W'(r_hdr);
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= w_i_p1;
        end
        case (i_cmd.k_op)
            K_CNT:   r_k <= r_cnt;
            K_I_P1:  r_k <= w_i_p1;
            K_I:     r_k <= r_i;
            K_DEC:   r_k <= r_k - CNT_W'(1);
            K_INC:   r_k <= w_k_p1;
            default: r_k <= r_k;
        endcase
        if (i_cmd.cur_load) begin
            r_cur <= w_rd;
        end else if (i_cmd.merge_next) begin
            r_cur.cap <= cap_sum(r_cur.cap, r_ovh, w_rd.cap);
        end
        if (i_cmd.publish) begin
            r_ostatus <= r_st;
            r_ograddr <= r_grant;
        end
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.ready      = r_ready;
        o_stat.scan_end   = (r_i >= r_cnt);
        o_stat.alloc_hit  = !w_rd.used && (w_rd.cap >= r_req);
        o_stat.free_hit   = w_rd.used && ((w_rd.off + ADDR_W'(r_hdr)) == r_addr);
        o_stat.split      = ((CAP_W+1)'(r_cur.cap) > w_req_ovh)
                            && (r_cnt < CNT_W'(MAX_SEGMENTS));
        o_stat.nxt_exists = (w_i_p1 < r_cnt);
        o_stat.prv_exists = (r_i != '0);
        o_stat.rd_free    = !w_rd.used;
        o_stat.su_more    = (r_k > w_i_p1);
        o_stat.sd_more    = (w_k_p1 < r_cnt);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_tdata  = OUT_TDATA_W'(r_ograddr);
    assign o_out_status = r_ostatus;
endmodule

/* hw/rtl/ffsa_ctrl.sv */
// Controller state machine that sequences scans, table shifts and merges.
`timescale 1ns / 1ps
module ffsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffsa_pkg::t_stat i_stat,
    output ffsa_pkg::t_cmd  o_cmd
);
    import ffsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.k_op = K_HOLD;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                if (i_stat.mode == MODE_INIT) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_INIT;
                    o_cmd.do_init = 1'b1;
                end else if (i_stat.mode == MODE_ALLOC || i_stat.mode == MODE_FREE) begin
                    if (!i_stat.ready) begin
                        o_cmd.st_we  = 1'b1;
                        o_cmd.st_val = ST_NOT_READY;
                    end else begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = (i_stat.mode == MODE_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.mode == MODE_ALLOC && i_stat.alloc_hit) begin
                    o_cmd.cur_load = 1'b1;
                    n_state        = S_AL_DEC;
                end else if (i_stat.mode == MODE_FREE && i_stat.free_hit) begin
                    o_cmd.cur_load = 1'b1;
                    n_state        = S_FR_NRD;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_AL_DEC: begin
                o_cmd.grant_we = 1'b1;
                if (i_stat.split) begin
                    o_cmd.k_op = K_CNT;
                    n_state    = S_SU_RD;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_GRANT_FULL;
                    n_state      = S_DONE;
                end
            end
            S_SU_RD: begin
                if (i_stat.su_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_K_M1;
                    n_state      = S_SU_WR;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_SPLIT_NEW;
                    n_state      = S_AL_WR;
                end
            end
            S_SU_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.k_op   = K_DEC;
                n_state      = S_SU_RD;
            end
            S_AL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_GRANT_REQ;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_FR_NRD: begin
                if (i_stat.nxt_exists) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I_P1;
                    n_state      = S_FR_NCHK;
                end else begin
                    n_state = S_FR_PRD;
                end
            end
            S_FR_NCHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.merge_next = 1'b1;
                    o_cmd.k_op       = K_I_P1;
                    n_state          = S_NM_RD;
                end else begin
                    n_state = S_FR_PRD;
                end
            end
            S_NM_RD: begin
                if (i_stat.sd_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_K_P1;
                    n_state      = S_NM_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FR_PRD;
                end
            end
            S_NM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.k_op   = K_INC;
                n_state      = S_NM_RD;
            end
            S_FR_PRD: begin
                if (i_stat.prv_exists) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I_M1;
                    n_state      = S_FR_PCHK;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_FREE;
                    n_state      = S_DONE;
                end
            end
            S_FR_PCHK: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.rd_free) begin
                    o_cmd.wr_sel = WR_PREV_MERGE;
                    o_cmd.k_op   = K_I;
                    n_state      = S_PM_RD;
                end else begin
                    o_cmd.wr_sel = WR_FREE;
                    n_state      = S_DONE;
                end
            end
            S_PM_RD: begin
                if (i_stat.sd_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_K_P1;
                    n_state      = S_PM_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_PM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.k_op   = K_INC;
                n_state      = S_PM_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

/* hw/rtl/first_fit_segment_allocator.sv */
// Top level of the first-fit segment allocator with coalescing of freed segments.
//
//  Channel  | Direction | Content
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: mode; tdata: request_size, address
//  m_axis   | out       | tuser: status; tdata: granted_address
//  cfg      | in        | i_cfg_we, i_cfg_idx, i_cfg_data (pool, header, overhead)
//
// Init, mode 3 or a pool that is not ready pass S_IDLE, S_DISP and S_DONE only; each
// table entry scanned adds S_SCAN_RD and S_SCAN_CHK, each entry moved by a split or a
// merge adds a read and a write state, and the neighbour checks of a free may add S_FR_NRD,
// S_FR_NCHK, S_FR_PRD and S_FR_PCHK, all set by the single read port of the table.
// Reset is synchronous and needs no clearing pass; the table is read only below its count.
// A result waits in the output register while the next request is already taken.
`timescale 1ns / 1ps
module first_fit_segment_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ffsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // request_size, address
    input  logic [1:0]                       s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ffsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // granted_address
    output logic [1:0]                       m_axis_tuser,  // status
    input  logic                             i_cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ffsa_pkg::CAP_W-1:0]       i_cfg_data
);
    import ffsa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ffsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    ffsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (s_axis_tuser),
        .i_tdata     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_status(m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> w_stat.out_free)
        else $error("result published over an unread result");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_split_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_en && w_cmd.wr_sel == WR_SPLIT_NEW) |-> w_stat.split)
        else $error("segment split without room or without a large enough remainder");

    a_grant_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.grant_we |-> $past(w_cmd.cur_load))
        else $error("address granted without a found segment");
`endif
endmodule

/* verif/first_fit_segment_allocator_test.sv */
// Self-checking testbench of the first-fit segment allocator with its own table predictor.
`timescale 1ns / 1ps
module first_fit_segment_allocator_test;
    import ffsa_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct packed {
        logic [ADDR_W-1:0] granted;
        t_status           status;
    } t_grant;

    class grant_ledger;
        logic [CAP_W-1:0]  pool_size;
        logic [BYTE_W-1:0] header_bytes;
        logic [BYTE_W-1:0] overhead_bytes;
        logic [ADDR_W-1:0] seg_off [MAX_SEGMENTS];
        logic [CAP_W-1:0]  seg_cap [MAX_SEGMENTS];
        logic              seg_used [MAX_SEGMENTS];
        int                seg_count;
        logic              ready;
        t_grant            pending [$];
        int                mismatches;
        logic [ADDR_W-1:0] live [$];

        function new();
            pool_size = POOL_SIZE_RESET;
            header_bytes = HEADER_RESET;
            overhead_bytes = OVERHEAD_RESET;
            seg_count = 0;
            ready = 1'b0;
            mismatches = 0;
            foreach (seg_used[k]) seg_used[k] = 1'b0;
        endfunction

        function void drop_entry(int idx);
            for (int k = idx; k + 1 < seg_count; k++) begin
                seg_off[k] = seg_off[k+1];
                seg_cap[k] = seg_cap[k+1];
                seg_used[k] = seg_used[k+1];
            end
            seg_count--;
        endfunction

        function logic [CAP_W-1:0] sat_sum(logic [CAP_W-1:0] a, logic [CAP_W-1:0] c);
            longint s;
            s = longint'(a) + longint'(overhead_bytes) + longint'(c);
            return (s > longint'(CAP_MAX)) ? CAP_MAX : CAP_W'(s);
        endfunction

        function void note_request(t_mode mode, logic [CAP_W-1:0] req, logic [ADDR_W-1:0] addr);
            t_grant g;
            int i;
            longint cap;
            g.granted = '0;
            g.status = ST_OK;
            if (mode == MODE_INIT) begin
                seg_off[0] = '0;
                seg_cap[0] = (pool_size >= overhead_bytes) ? pool_size - overhead_bytes : '0;
                seg_used[0] = 1'b0;
                seg_count = 1;
                ready = 1'b1;
                live.delete();
            end else if (mode == MODE_ALLOC) begin
                if (!ready) g.status = ST_NOT_READY;
                else begin
                    for (i = 0; i < seg_count; i++)
                        if (!seg_used[i] && seg_cap[i] >= req) break;
                    if (i >= seg_count) g.status = ST_NO_FIT;
                    else begin
                        cap = seg_cap[i];
                        if (cap > longint'(req) + overhead_bytes && seg_count < MAX_SEGMENTS) begin
                            for (int k = seg_count; k > i + 1; k--) begin
                                seg_off[k] = seg_off[k-1];
                                seg_cap[k] = seg_cap[k-1];
                                seg_used[k] = seg_used[k-1];
                            end
                            seg_off[i+1] = seg_off[i] + ADDR_W'(req) + ADDR_W'(overhead_bytes);
                            seg_cap[i+1] = CAP_W'(cap - req - overhead_bytes);
                            seg_used[i+1] = 1'b0;
                            seg_count++;
                            seg_cap[i] = req;
                        end
                        seg_used[i] = 1'b1;
                        g.granted = seg_off[i] + ADDR_W'(header_bytes);
                        live.push_back(g.granted);
                    end
                end
            end else if (mode == MODE_FREE) begin
                if (!ready) g.status = ST_NOT_READY;
                else begin
                    for (i = 0; i < seg_count; i++)
                        if (seg_used[i] && seg_off[i] + ADDR_W'(header_bytes) == addr) break;
                    if (i >= seg_count) g.status = ST_UNKNOWN;
                    else begin
                        seg_used[i] = 1'b0;
                        if (i + 1 < seg_count && !seg_used[i+1]) begin
                            seg_cap[i] = sat_sum(seg_cap[i], seg_cap[i+1]);
                            drop_entry(i + 1);
                        end
                        if (i > 0 && !seg_used[i-1]) begin
                            seg_cap[i-1] = sat_sum(seg_cap[i-1], seg_cap[i]);
                            drop_entry(i);
                        end
                    end
                end
            end
            pending.push_back(g);
        endfunction

        function void check_grant(logic [ADDR_W-1:0] granted, t_status status);
            t_grant g;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response: address %h status %0d", granted, status);
                return;
            end
            g = pending.pop_front();
            if (g.granted !== granted || g.status !== status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected address %h status %0d, got %h status %0d",
                             g.granted, g.status, granted, status);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CAP_W-1:0]       i_cfg_data = '0;

    grant_ledger ledger = new();
    int idle_cycles = 0;
    bit stimulus_done = 1'b0;

    always #1 i_clk = ~i_clk;

    first_fit_segment_allocator DUT (.*);

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_grant(m_axis_tdata[ADDR_W-1:0], t_status'(m_axis_tuser));
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("first_fit_segment_allocator verification failed");
            $finish;
        end
    end

    // Response side: random back-pressure with occasional long stalls.
    initial begin
        int g;
        wait (i_rst_n);
        forever begin
            g = gap_length();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_request(t_mode mode, logic [CAP_W-1:0] req, logic [ADDR_W-1:0] addr);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= IN_TDATA_W'({addr, req});
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_request(mode, req, addr);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_POOL_SIZE: ledger.pool_size = value;
            CFG_HEADER:    ledger.header_bytes = value[BYTE_W-1:0];
            CFG_OVERHEAD:  ledger.overhead_bytes = value[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_request(int pool);
        int r;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 2) send_request(MODE_INIT, CAP_W'($urandom), ADDR_W'($urandom));
        else if (r < 4) send_request(MODE_NONE, CAP_W'($urandom), ADDR_W'($urandom));
        else if (r < 55) begin
            if ($urandom_range(0, 9) == 0) send_request(MODE_ALLOC, CAP_W'($urandom), '0);
            else send_request(MODE_ALLOC, CAP_W'($urandom_range(0, pool / 12)),
                              ADDR_W'($urandom));
        end else begin
            if (ledger.live.size() != 0 && $urandom_range(0, 9) < 8) begin
                r = $urandom_range(0, ledger.live.size() - 1);
                a = ledger.live[r];
                if ($urandom_range(0, 3) != 0) ledger.live.delete(r);
            end else a = ADDR_W'($urandom);
            send_request(MODE_FREE, CAP_W'($urandom), a);
        end
    endtask

    initial begin
        int pools [4];
        pools = '{65536, 64, 1048576, 3000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(MODE_ALLOC, 21'd16, '0);
        send_request(MODE_FREE, '0, 20'd52);
        send_request(MODE_NONE, CAP_MAX, '1);
        send_request(MODE_INIT, '0, '0);
        send_request(MODE_ALLOC, 21'd100, '0);
        send_request(MODE_ALLOC, 21'd0, '0);
        send_request(MODE_ALLOC, CAP_MAX, '1);
        send_request(MODE_ALLOC, 21'd200, '0);
        send_request(MODE_FREE, '0, 20'd52);
        send_request(MODE_FREE, '0, 20'd52);
        send_request(MODE_FREE, '0, '1);
        send_request(MODE_FREE, '0, 20'd264);
        send_request(MODE_ALLOC, 21'd65480 - 21'd100, '0);
        send_request(MODE_FREE, '0, 20'd316);
        send_request(MODE_INIT, '0, '0);
        for (int k = 0; k < 66; k++) send_request(MODE_ALLOC, 21'd1, '0);
        drain();

        foreach (pools[p]) begin
            write_reg(CFG_POOL_SIZE, CAP_W'(pools[p]));
            write_reg(CFG_HEADER, (p == 1) ? 21'd255 : (p == 2) ? 21'd0 : 21'($urandom_range(0, 255)));
            write_reg(CFG_OVERHEAD, (p == 1) ? 21'd255 : (p == 2) ? 21'd0 : 21'($urandom_range(0, 255)));
            send_request(MODE_INIT, '0, '0);
            for (int n = 0; n < 270; n++) random_request(pools[p]);
            drain();
        end
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("first_fit_segment_allocator verification clean");
        else
            $display("first_fit_segment_allocator verification failed");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ram.sv
hw/rtl/ffsa_dp.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/first_fit_segment_allocator.sv
verif/first_fit_segment_allocator_test.sv
